// ===== rtl/core/tun_pkg.sv =====
`default_nettype none
package tun_pkg;
    // output scale
    localparam int QBITS = 16;
    localparam logic [16:0] Q_ONE = 17'd32768;
    localparam logic [15:0] Q_MAX = 16'd32767;
endpackage
`default_nettype wire

// ===== rtl/core/triangle_unit_normal_unit.sv =====
`default_nettype none
// Unit face normal of a triangle streamed one item per clock. Each item carries
// three vertices; the result is the normalized cross product of (b-a) and (c-b)
// in Q1.15, rounded to nearest with ties away from zero; a zero cross product
// returns zeros and degenerate=1. The pipeline stages are edge, product, cross,
// magnitude, square, sum, divider setup, 16 quotient-digit stages and output;
// throughput one item per cycle, since every stage is a register stage and the
// whole pipeline moves on one enable. m_tready low with a result waiting stalls
// the whole pipeline and s_tready with it.
module triangle_unit_normal_unit #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    input  wire logic [((9*COORD_BITS+7)/8)*8-1:0] s_tdata,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // unit_x, unit_y, unit_z, degenerate, zero fill
    output logic [55:0]                   m_tdata
);
    localparam int CB = COORD_BITS;
    localparam int NB = 2 * CB + 3;
    localparam int MB = NB - 1;
    localparam int SQB = 2 * MB;
    localparam int DB = SQB + 2;
    localparam int LAT = 24;
    localparam int FL = 20;

    logic en;
    logic [LAT-1:0] vld_reg;
    logic signed [NB-1:0] n_x, n_y, n_z;
    logic [MB-1:0] m_reg [3];
    logic [SQB-1:0] sq_reg [3];
    logic [SQB-1:0] sqd_reg [3];
    logic [DB-1:0] d_reg;
    logic [2:0] neg_reg [FL];
    logic zero_reg [FL];
    logic [15:0] q [3];
    logic [15:0] u_reg [3];
    logic deg_reg;

    assign en = m_tready || !m_tvalid;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    tun_cross #(.CB(CB)) u_cross (
        .aclk(aclk), .en(en), .vtx(s_tdata[9*CB-1:0]),
        .n_x_reg(n_x), .n_y_reg(n_y), .n_z_reg(n_z)
    );

    // magnitudes, signs and zero test
    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg[0] <= MB'(n_x[NB-1] ? -n_x : n_x);
            m_reg[1] <= MB'(n_y[NB-1] ? -n_y : n_y);
            m_reg[2] <= MB'(n_z[NB-1] ? -n_z : n_z);
            neg_reg[0] <= {n_z[NB-1], n_y[NB-1], n_x[NB-1]};
            zero_reg[0] <= (n_x == '0) && (n_y == '0) && (n_z == '0);
        end
    end

    // component squares
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= m_reg[i] * m_reg[i];
            end
        end
    end

    // squared length
    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= DB'(sq_reg[0]) + DB'(sq_reg[1]) + DB'(sq_reg[2]);
            for (int i = 0; i < 3; i++) begin
                sqd_reg[i] <= sq_reg[i];
            end
        end
    end

    // sign and degenerate flag alongside the later stages
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 1; s < FL; s++) begin
                neg_reg[s] <= neg_reg[s-1];
                zero_reg[s] <= zero_reg[s-1];
            end
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_div
        tun_norm #(.MB(MB), .DB(DB)) u_norm (
            .aclk(aclk), .en(en), .msq(sqd_reg[g]), .dsq(d_reg), .q_out(q[g])
        );
    end

    // sign apply, saturate, output register
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (zero_reg[FL-1])
                    u_reg[i] <= '0;
                else if (neg_reg[FL-1][i])
                    u_reg[i] <= -q[i];
                else
                    u_reg[i] <= (q[i] > tun_pkg::Q_MAX) ? tun_pkg::Q_MAX : q[i];
            end
            deg_reg <= zero_reg[FL-1];
        end
    end

    assign m_tdata = {7'd0, deg_reg, u_reg[2], u_reg[1], u_reg[0]};
endmodule
`default_nettype wire

// ===== rtl/core/tun_cross.sv =====
`default_nettype none
module tun_cross #(
    parameter int CB = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 en,
    input  wire logic [9*CB-1:0]      vtx,
    output logic signed [2*CB+2:0]    n_x_reg,
    output logic signed [2*CB+2:0]    n_y_reg,
    output logic signed [2*CB+2:0]    n_z_reg
);
    localparam int EB = CB + 1;
    localparam int PB = 2 * CB + 3;
    logic signed [EB-1:0] e0_reg [3];
    logic signed [EB-1:0] e1_reg [3];
    logic signed [2*EB-1:0] p_reg [6];

    // edge vectors
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                e0_reg[i] <= EB'($signed(vtx[(3+i)*CB +: CB])) - EB'($signed(vtx[i*CB +: CB]));
                e1_reg[i] <= EB'($signed(vtx[(6+i)*CB +: CB]))
                           - EB'($signed(vtx[(3+i)*CB +: CB]));
            end
        end
    end

    // partial products, edge width by edge width
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                p_reg[2*i]   <= e0_reg[(i+1)%3] * e1_reg[(i+2)%3];
                p_reg[2*i+1] <= e0_reg[(i+2)%3] * e1_reg[(i+1)%3];
            end
        end
    end

    // cross product
    always_ff @(posedge aclk) begin
        if (en) begin
            n_x_reg <= PB'(p_reg[0]) - PB'(p_reg[1]);
            n_y_reg <= PB'(p_reg[2]) - PB'(p_reg[3]);
            n_z_reg <= PB'(p_reg[4]) - PB'(p_reg[5]);
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/tun_norm.sv =====
`default_nettype none
// one restoring step per stage: largest q with (2q-1)^2 * d <= 2^32 * m^2
// the slack r = 2^32 * m^2 - (2q-1)^2 * d and y = (2q-1) * d are kept,
// so setting bit b costs only shifts and adds:
//   fits when r - 2^(b+2) * y - 2^(2b+2) * d >= 0, then y grows by 2^(b+1) * d
module tun_norm #(
    parameter int MB = 34,
    parameter int DB = 70
) (
    input  wire logic            aclk,
    input  wire logic            en,
    input  wire logic [2*MB-1:0] msq,
    input  wire logic [DB-1:0]   dsq,
    output logic      [15:0]     q_out
);
    localparam int W  = DB + 36;
    localparam int SB = 16;
    logic signed [W-1:0] lhs;
    logic signed [W-1:0] dwin;
    logic signed [W-1:0] r_reg [SB];
    logic signed [W-1:0] y_reg [SB];
    logic        [DB-1:0] d_reg [SB];
    logic        [15:0]  q_reg [SB+1];
    logic signed [W-1:0] dw    [SB];
    logic signed [W-1:0] rem   [SB];
    logic                fit   [SB];

    assign lhs  = W'(msq) << 32;
    assign dwin = W'(dsq);

    // trial slack of each digit stage
    always_comb begin
        for (int s = 0; s < SB; s++) begin
            dw[s]  = W'(d_reg[s]);
            rem[s] = r_reg[s] - (y_reg[s] <<< (17 - s)) - (dw[s] <<< (32 - 2 * s));
            fit[s] = !rem[s][W-1];
        end
    end

    // setup stage: q = 0 gives slack lhs - d and y = -d
    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg[0] <= lhs - dwin;
            y_reg[0] <= -dwin;
            d_reg[0] <= dsq;
            q_reg[0] <= '0;
        end
    end

    // pipeline of digit stages
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int s = 0; s < SB - 1; s++) begin
                r_reg[s+1] <= fit[s] ? rem[s] : r_reg[s];
                y_reg[s+1] <= fit[s] ? y_reg[s] + (dw[s] <<< (16 - s)) : y_reg[s];
                d_reg[s+1] <= d_reg[s];
            end
            for (int s = 0; s < SB; s++) begin
                q_reg[s+1] <= fit[s] ? (q_reg[s] | (16'd1 << (15 - s))) : q_reg[s];
            end
        end
    end

    assign q_out = q_reg[SB];
endmodule
`default_nettype wire
